// File: sv/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, register indexes,
// operation codes and the controller state type.
// No dependencies; used by the interfaces and the core.
`default_nettype none

package fbpa_pkg;

	// Pool geometry.
	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W      = LINK_W;

	// Field widths fixed by the interface.
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 32;
	localparam int OFF_W   = 20;
	localparam int FREE_W  = 16;
	localparam int BS_W    = 13;
	localparam int CFG_CNT_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W   = BS_W;

	// Block size limits and reset values.
	localparam logic [BS_W-1:0] BS_MIN   = BS_W'(8);
	localparam logic [BS_W-1:0] BS_MAX   = BS_W'(4096);
	localparam logic [BS_W-1:0] BS_RST   = BS_W'(64);
	localparam logic [CFG_CNT_W-1:0] CFG_CNT_RST = CFG_CNT_W'(256);
	localparam logic [FREE_W-1:0] FREE_MAX = '1;
	localparam int CNT_RST_I  = (256 > MAX_BLOCKS) ? MAX_BLOCKS : 256;
	localparam int FREE_RST_I = (CNT_RST_I > 65535) ? 65535 : CNT_RST_I;
	localparam logic [CNT_W-1:0]  CNT_RST  = CNT_W'(CNT_RST_I);
	localparam logic [FREE_W-1:0] FREE_RST = FREE_W'(FREE_RST_I);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

	// Divider geometry: two quotient bits per cycle.
	localparam int REM_W   = BS_W + IDX_W;
	localparam int DVS_W   = REM_W + 1;
	localparam int DIV_CYC = (IDX_W + 1) / 2;
	localparam int QB_W    = 2 * DIV_CYC;
	localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
	localparam int SH_W    = STEP_W + 1;
	localparam int GPROD_W = IDX_W + BS_W;
	localparam int LPROD_W = BS_W + CNT_W;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE  = 1'b0,
		CFG_BLOCK_COUNT = 1'b1
	} cfg_idx_t;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_DIV,
		ST_PUSH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: sv/fbpa_if.sv
// Request and response channel interfaces of the fixed block pool allocator.
// Depends on fbpa_pkg for field widths.
`default_nettype none

interface fbpa_req_if;
	logic                       valid;
	logic                       ready;
	logic [fbpa_pkg::OP_W-1:0]   operation;
	logic [fbpa_pkg::ADDR_W-1:0] address_offset;

	modport source (output valid, output operation, output address_offset, input ready);
	modport sink   (input valid, input operation, input address_offset, output ready);
endinterface

interface fbpa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [fbpa_pkg::OFF_W-1:0]  granted_offset;
	logic [fbpa_pkg::FREE_W-1:0] free_blocks;
	logic                       is_full;

	modport source (output valid, output ok, output granted_offset, output free_blocks,
		output is_full, input ready);
	modport sink   (input valid, input ok, input granted_offset, input free_blocks,
		input is_full, output ready);
endinterface

`default_nettype wire

// File: sv/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: LIFO free list kept in a link memory.
// Requests arrive on req (operation, address_offset), one result per request
// leaves on rsp (ok, granted_offset, free_blocks, is_full).
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 block size, 1 block count); write only while no transaction is in flight.
// Sequence, from request accept to the output register:
//   allocate   one link memory read, then the offset multiply;
//              straight to the result when the pool is empty,
//   free       offset divide, two quotient bits per cycle, then push,
//   init and unused codes go straight to the result.
// A new request is taken once the previous one has reached the output register,
// so one result may wait in the output register while the next one is worked on.
// If rsp stalls, the finished result holds in the controller until the output
// register is free; req is not ready meanwhile.
// Reset builds the list 0..255 at once: per-entry valid bits mark link entries
// written since the last init, and unwritten entries read as the ordered chain.
// Init rebuilds the same way at once; there is no clearing pass.
// Depends on fbpa_pkg and the channel interfaces in fbpa_if.sv.
`default_nettype none

module fixed_block_pool_allocator_core (
	input  wire                              clk,
	input  wire                              arst_n,
	fbpa_req_if.sink                         req,
	fbpa_rsp_if.source                       rsp,
	input  wire                              cfg_we,
	input  wire [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [fbpa_pkg::CFG_W-1:0]        cfg_wdata
);

	// Configuration registers.
	logic [fbpa_pkg::BS_W-1:0]      cfg_bs_q;
	logic [fbpa_pkg::CFG_CNT_W-1:0] cfg_cnt_q;

	// Effective block size and count.
	logic [fbpa_pkg::BS_W-1:0]  eff_bs;
	logic [fbpa_pkg::CNT_W-1:0] eff_cnt;
	logic [fbpa_pkg::FREE_W-1:0] init_free;
	logic [fbpa_pkg::REM_W-1:0] pool_limit;

	// Free list state.
	logic [fbpa_pkg::LINK_W-1:0]    head_q;
	logic [fbpa_pkg::FREE_W-1:0]    free_q;
	logic [fbpa_pkg::CNT_W-1:0]     built_cnt_q;
	logic [fbpa_pkg::MAX_BLOCKS-1:0] link_vld_q;
	logic [fbpa_pkg::LINK_W-1:0]    link_mem [fbpa_pkg::MAX_BLOCKS];
	logic [fbpa_pkg::LINK_W-1:0]    link_rd_q;
	logic [fbpa_pkg::IDX_W-1:0]     head_idx;
	logic [fbpa_pkg::LINK_W-1:0]    head_dflt;
	logic [fbpa_pkg::LINK_W-1:0]    head_next;

	// Controller.
	fbpa_pkg::state_t state_q, state_d;
	logic req_acc;
	logic out_load;
	logic alloc_ok;

	// Per-item working registers.
	logic                        range_ok_q;
	logic [fbpa_pkg::REM_W-1:0]  rem_q;
	logic [fbpa_pkg::QB_W-1:0]   quo_q;
	logic [fbpa_pkg::STEP_W-1:0] step_q;
	logic [fbpa_pkg::REM_W-1:0]  rem_d;
	logic [fbpa_pkg::QB_W-1:0]   quo_d;
	logic                        push_ok;
	logic [fbpa_pkg::IDX_W-1:0]  push_idx;
	logic                        res_ok_q;
	logic [fbpa_pkg::OFF_W-1:0]  res_gr_q;

	// Output register.
	logic                        out_vld_q;
	logic                        out_ok_q;
	logic [fbpa_pkg::OFF_W-1:0]  out_gr_q;
	logic [fbpa_pkg::FREE_W-1:0] out_free_q;

	// Clamp the configured values to their legal ranges.
	always_comb begin
		if (cfg_bs_q < fbpa_pkg::BS_MIN) begin
			eff_bs = fbpa_pkg::BS_MIN;
		end else if (cfg_bs_q > fbpa_pkg::BS_MAX) begin
			eff_bs = fbpa_pkg::BS_MAX;
		end else begin
			eff_bs = cfg_bs_q;
		end
		if (cfg_cnt_q == '0) begin
			eff_cnt = fbpa_pkg::CNT_W'(1);
		end else if (32'(cfg_cnt_q) > 32'(fbpa_pkg::MAX_BLOCKS)) begin
			eff_cnt = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
		end else begin
			eff_cnt = fbpa_pkg::CNT_W'(cfg_cnt_q);
		end
		if (32'(eff_cnt) > 32'(fbpa_pkg::FREE_MAX)) begin
			init_free = fbpa_pkg::FREE_MAX;
		end else begin
			init_free = fbpa_pkg::FREE_W'(eff_cnt);
		end
	end

	// Pool size in bytes, taken from the registers as they stand.
	assign pool_limit = fbpa_pkg::REM_W'(fbpa_pkg::LPROD_W'(eff_bs)
		* fbpa_pkg::LPROD_W'(eff_cnt));

	// Head lookup: an entry not written since the last init reads as the chain.
	assign head_idx  = head_q[fbpa_pkg::IDX_W-1:0];
	assign head_dflt = ((fbpa_pkg::LINK_W'(head_idx) + fbpa_pkg::LINK_W'(1)) < built_cnt_q)
		? (fbpa_pkg::LINK_W'(head_idx) + fbpa_pkg::LINK_W'(1)) : fbpa_pkg::NULL_LINK;
	assign head_next = link_vld_q[head_idx] ? link_rd_q : head_dflt;
	assign alloc_ok  = (free_q != '0) && (head_q < fbpa_pkg::NULL_LINK);

	// Two restoring division steps per cycle.
	always_comb begin
		logic [fbpa_pkg::DVS_W-1:0] dvs;
		logic [fbpa_pkg::SH_W-1:0]  sh;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 1; k >= 0; k--) begin
			sh  = {step_q, 1'(k)};
			dvs = fbpa_pkg::DVS_W'(eff_bs) << sh;
			if ({1'b0, rem_d} >= dvs) begin
				rem_d = fbpa_pkg::REM_W'({1'b0, rem_d} - dvs);
				quo_d[sh] = 1'b1;
			end
		end
	end

	// A free takes effect when in range and block aligned.
	assign push_ok  = range_ok_q && (rem_q == '0);
	assign push_idx = quo_q[fbpa_pkg::IDX_W-1:0];

	// Next state and handshake strobes.
	always_comb begin
		state_d  = state_q;
		req_acc  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				if (req.valid) begin
					req_acc = 1'b1;
					unique case (req.operation)
						fbpa_pkg::OP_ALLOC: state_d = alloc_ok ? fbpa_pkg::ST_ALLOC
							: fbpa_pkg::ST_DONE;
						fbpa_pkg::OP_FREE:  state_d = fbpa_pkg::ST_DIV;
						default:            state_d = fbpa_pkg::ST_DONE;
					endcase
				end
			end
			fbpa_pkg::ST_ALLOC: state_d = fbpa_pkg::ST_DONE;
			fbpa_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = fbpa_pkg::ST_PUSH;
				end
			end
			fbpa_pkg::ST_PUSH: state_d = fbpa_pkg::ST_DONE;
			fbpa_pkg::ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = fbpa_pkg::ST_IDLE;
				end
			end
			default: state_d = fbpa_pkg::ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bs_q  <= fbpa_pkg::BS_RST;
			cfg_cnt_q <= fbpa_pkg::CFG_CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbpa_pkg::CFG_BLOCK_SIZE:  cfg_bs_q  <= cfg_wdata;
				fbpa_pkg::CFG_BLOCK_COUNT: cfg_cnt_q <= cfg_wdata[fbpa_pkg::CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Free list control state: head, free count, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			free_q      <= fbpa_pkg::FREE_RST;
			built_cnt_q <= fbpa_pkg::CNT_RST;
			link_vld_q  <= '0;
		end else begin
			if (req_acc && (req.operation == fbpa_pkg::OP_INIT)) begin
				head_q      <= '0;
				free_q      <= init_free;
				built_cnt_q <= eff_cnt;
				link_vld_q  <= '0;
			end
			if (state_q == fbpa_pkg::ST_ALLOC) begin
				head_q <= head_next;
				free_q <= free_q - fbpa_pkg::FREE_W'(1);
			end
			if ((state_q == fbpa_pkg::ST_PUSH) && push_ok) begin
				head_q               <= fbpa_pkg::LINK_W'(push_idx);
				link_vld_q[push_idx] <= 1'b1;
				if (free_q != fbpa_pkg::FREE_MAX) begin
					free_q <= free_q + fbpa_pkg::FREE_W'(1);
				end
			end
		end
	end

	// Link memory: one write port for pushes, one registered read at the head.
	always_ff @(posedge clk) begin
		if ((state_q == fbpa_pkg::ST_PUSH) && push_ok) begin
			link_mem[push_idx] <= head_q;
		end
		link_rd_q <= link_mem[head_idx];
	end

	// Per-item working registers: divider, result ok and granted offset.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			range_ok_q <= req.address_offset < fbpa_pkg::ADDR_W'(pool_limit);
			rem_q      <= req.address_offset[fbpa_pkg::REM_W-1:0];
			quo_q      <= '0;
			step_q     <= fbpa_pkg::STEP_W'(fbpa_pkg::DIV_CYC - 1);
			res_gr_q   <= '0;
			res_ok_q   <= req.operation == fbpa_pkg::OP_INIT;
		end
		if (state_q == fbpa_pkg::ST_DIV) begin
			rem_q  <= rem_d;
			quo_q  <= quo_d;
			step_q <= step_q - fbpa_pkg::STEP_W'(1);
		end
		if (state_q == fbpa_pkg::ST_ALLOC) begin
			res_ok_q <= 1'b1;
			res_gr_q <= fbpa_pkg::OFF_W'(fbpa_pkg::GPROD_W'(head_idx)
				* fbpa_pkg::GPROD_W'(eff_bs));
		end
		if (state_q == fbpa_pkg::ST_PUSH) begin
			res_ok_q <= push_ok;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q   <= res_ok_q;
			out_gr_q   <= res_gr_q;
			out_free_q <= free_q;
		end
	end

	// Channel ports.
	assign req.ready          = (state_q == fbpa_pkg::ST_IDLE);
	assign rsp.valid          = out_vld_q;
	assign rsp.ok             = out_ok_q;
	assign rsp.granted_offset = out_gr_q;
	assign rsp.free_blocks    = out_free_q;
	assign rsp.is_full        = (out_free_q == '0);

endmodule

`default_nettype wire

// File: tb/fixed_block_pool_allocator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator_core: a queue-fed driver,
// a monitor with a free-list predictor, and random handshake idling.
// Depends on fbpa_pkg and the channel interfaces in fbpa_if.sv.

module fixed_block_pool_allocator_core_tb;

	localparam logic [fbpa_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int PHASES = 16;
	localparam int ITEMS_PER_PHASE = 118;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [fbpa_pkg::OP_W-1:0]   op;
		logic [fbpa_pkg::ADDR_W-1:0] addr;
	} pool_req_t;

	typedef struct {
		logic                        ok;
		logic [fbpa_pkg::OFF_W-1:0]  offset;
		logic [fbpa_pkg::FREE_W-1:0] free;
		logic                        full;
	} pool_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fbpa_pkg::CFG_W-1:0] cfg_wdata;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	fixed_block_pool_allocator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Stimulus and scoreboard storage.
	pool_req_t pending_reqs[$];
	pool_rsp_t expected_results[$];
	int unsigned queued_total;
	int unsigned accepted_total;
	int unsigned result_total;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic req_taken;

	// Predictor copy of the pool and its registers.
	logic [fbpa_pkg::LINK_W-1:0] link_mem [fbpa_pkg::MAX_BLOCKS];
	logic [fbpa_pkg::LINK_W-1:0] pool_head;
	logic [fbpa_pkg::FREE_W-1:0] pool_free;
	logic [fbpa_pkg::BS_W-1:0] reg_bs;
	logic [fbpa_pkg::CFG_CNT_W-1:0] reg_cnt;

	// Effective block size and block count after range limiting.
	function automatic logic [fbpa_pkg::BS_W-1:0] size_clamp(logic [fbpa_pkg::BS_W-1:0] v);
		if (v < fbpa_pkg::BS_MIN)
			return fbpa_pkg::BS_MIN;
		if (v > fbpa_pkg::BS_MAX)
			return fbpa_pkg::BS_MAX;
		return v;
	endfunction

	function automatic logic [fbpa_pkg::CFG_CNT_W-1:0] count_clamp(
		logic [fbpa_pkg::CFG_CNT_W-1:0] v);
		if (v == 0)
			return fbpa_pkg::CFG_CNT_W'(1);
		if (v > fbpa_pkg::MAX_BLOCKS)
			return fbpa_pkg::CFG_CNT_W'(fbpa_pkg::MAX_BLOCKS);
		return v;
	endfunction

	// Chain blocks 0..count-1 in order and mark them all free.
	task automatic rebuild_free_list();
		int unsigned c;
		c = count_clamp(reg_cnt);
		for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++)
			link_mem[i] = (i + 1 < c) ? fbpa_pkg::LINK_W'(i + 1) : fbpa_pkg::NULL_LINK;
		pool_head = '0;
		pool_free = (c > 65535) ? fbpa_pkg::FREE_MAX : fbpa_pkg::FREE_W'(c);
	endtask

	// Apply one accepted request to the predicted pool and queue its result.
	task automatic predict_pool_op(pool_req_t r);
		logic [31:0] bs;
		logic [31:0] limit;
		logic [31:0] blk;
		pool_rsp_t res;
		bs = 32'(size_clamp(reg_bs));
		limit = bs * 32'(count_clamp(reg_cnt));
		res.ok = 1'b0;
		res.offset = '0;
		case (r.op)
			fbpa_pkg::OP_ALLOC: begin
				if (pool_free != 0 && pool_head < fbpa_pkg::NULL_LINK) begin
					blk = 32'(pool_head);
					pool_head = link_mem[blk];
					pool_free = pool_free - 1'b1;
					res.offset = fbpa_pkg::OFF_W'(blk * bs);
					res.ok = 1'b1;
				end
			end
			fbpa_pkg::OP_FREE: begin
				if (r.addr < limit && (r.addr % bs) == 0) begin
					blk = r.addr / bs;
					if (blk < fbpa_pkg::MAX_BLOCKS) begin
						link_mem[blk] = pool_head;
						pool_head = fbpa_pkg::LINK_W'(blk);
						if (pool_free != fbpa_pkg::FREE_MAX)
							pool_free = pool_free + 1'b1;
						res.ok = 1'b1;
					end
				end
			end
			fbpa_pkg::OP_INIT: begin
				rebuild_free_list();
				res.ok = 1'b1;
			end
			default: begin
			end
		endcase
		res.free = pool_free;
		res.full = (pool_free == 0);
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				result_total, name, got, want));
	endtask

	// Clock and the single reset pulse; every input starts at a known value.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fbpa_pkg::CFG_BLOCK_SIZE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.address_offset = '0;
		rsp_ch.ready = 1'b0;
		fork
			forever #10 clk = ~clk;
			begin
				repeat (7) @(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// Driver: holds a request until it is accepted, then maybe idles.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.operation <= pending_reqs[0].op;
				req_ch.address_offset <= pending_reqs[0].addr;
				void'(pending_reqs.pop_front());
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response sink stalls at random.
	always @(negedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: register writes, accepted requests and returned results.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			cycle_count++;
			if (cfg_we) begin
				case (cfg_index)
					fbpa_pkg::CFG_BLOCK_SIZE: reg_bs = cfg_wdata[fbpa_pkg::BS_W-1:0];
					fbpa_pkg::CFG_BLOCK_COUNT: reg_cnt = cfg_wdata[fbpa_pkg::CFG_CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with no request outstanding");
				end else begin
					check_field("ok", 32'(rsp_ch.ok), 32'(expected_results[0].ok));
					check_field("granted_offset", 32'(rsp_ch.granted_offset),
						32'(expected_results[0].offset));
					check_field("free_blocks", 32'(rsp_ch.free_blocks),
						32'(expected_results[0].free));
					check_field("is_full", 32'(rsp_ch.is_full),
						32'(expected_results[0].full));
					void'(expected_results.pop_front());
					result_total++;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				predict_pool_op('{op: req_ch.operation, addr: req_ch.address_offset});
				accepted_total++;
			end
			req_taken <= req_ch.valid && req_ch.ready;
		end
	end

	task automatic queue_request(logic [fbpa_pkg::OP_W-1:0] op,
		logic [fbpa_pkg::ADDR_W-1:0] addr);
		pending_reqs.push_back('{op: op, addr: addr});
		queued_total++;
	endtask

	// Mostly allocates and well-formed frees, with bad frees, reinits and noise.
	task automatic queue_random_request(logic [fbpa_pkg::BS_W-1:0] bs,
		logic [fbpa_pkg::CFG_CNT_W-1:0] cnt);
		int unsigned pick;
		int unsigned kind;
		logic [fbpa_pkg::ADDR_W-1:0] addr;
		pick = $urandom_range(99);
		kind = $urandom_range(2);
		if (pick < 42) begin
			queue_request(fbpa_pkg::OP_ALLOC, $urandom());
		end else if (pick < 76) begin
			queue_request(fbpa_pkg::OP_FREE, $urandom_range(cnt - 1) * bs);
		end else if (pick < 86) begin
			case (kind)
				0: addr = $urandom();
				1: addr = $urandom_range(cnt - 1) * bs + $urandom_range(bs - 1, 1);
				default: addr = (cnt + $urandom_range(3)) * bs;
			endcase
			queue_request(fbpa_pkg::OP_FREE, addr);
		end else if (pick < 94) begin
			queue_request(fbpa_pkg::OP_INIT, $urandom());
		end else begin
			queue_request(OP_RESERVED, $urandom());
		end
	endtask

	// Wait until every queued transaction has been answered, then let the core settle.
	task automatic wait_for_drain();
		while (accepted_total != queued_total || expected_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_register(fbpa_pkg::cfg_idx_t idx, logic [fbpa_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stimulus: directed checks at reset settings, then phases of random traffic.
	initial begin
		logic [fbpa_pkg::BS_W-1:0] gen_bs;
		logic [fbpa_pkg::CFG_CNT_W-1:0] gen_cnt;
		reg_bs = fbpa_pkg::BS_RST;
		reg_cnt = fbpa_pkg::CFG_CNT_RST;
		rebuild_free_list();
		gen_bs = fbpa_pkg::BS_RST;
		gen_cnt = fbpa_pkg::CFG_CNT_RST;
		send_idle_pct = 20;
		recv_idle_pct = 81;
		@(posedge arst_n);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 6) begin
				send_idle_pct = 20;
				recv_idle_pct = 81;
			end else if (phase < 11) begin
				send_idle_pct = 81;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if (phase == 0) begin
				// Pops, a good free, a double free, unaligned and out-of-range frees.
				queue_request(fbpa_pkg::OP_ALLOC, 32'h0);
				queue_request(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
				queue_request(fbpa_pkg::OP_FREE, 32'd64);
				queue_request(fbpa_pkg::OP_FREE, 32'd64);
				queue_request(fbpa_pkg::OP_FREE, 32'd63);
				queue_request(fbpa_pkg::OP_FREE, 32'd16384);
				queue_request(fbpa_pkg::OP_FREE, 32'd16320);
				queue_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
				queue_request(fbpa_pkg::OP_FREE, 32'd0);
				queue_request(OP_RESERVED, 32'hFFFF_FFFF);
				queue_request(fbpa_pkg::OP_INIT, 32'h5555_AAAA);
				queue_request(fbpa_pkg::OP_ALLOC, 32'hAAAA_5555);
			end else begin
				wait_for_drain();
				// Extreme and out-of-range register values first, then random ones.
				case (phase)
					1: begin gen_bs = 13'd0;    gen_cnt = 9'd0;   end
					2: begin gen_bs = 13'd7;    gen_cnt = 9'd1;   end
					3: begin gen_bs = 13'd8;    gen_cnt = 9'd256; end
					4: begin gen_bs = 13'd4096; gen_cnt = 9'd256; end
					5: begin gen_bs = 13'd8191; gen_cnt = 9'd511; end
					6: begin gen_bs = 13'd4097; gen_cnt = 9'd2;   end
					7: begin gen_bs = 13'd24;   gen_cnt = 9'd257; end
					default: begin
						gen_bs = $urandom_range(1)
							? fbpa_pkg::BS_W'(13'd8 << $urandom_range(9))
							: fbpa_pkg::BS_W'($urandom_range(8191));
						gen_cnt = $urandom_range(1)
							? fbpa_pkg::CFG_CNT_W'($urandom_range(16))
							: fbpa_pkg::CFG_CNT_W'($urandom_range(511));
					end
				endcase
				write_register(fbpa_pkg::CFG_BLOCK_SIZE, gen_bs);
				write_register(fbpa_pkg::CFG_BLOCK_COUNT, {4'($urandom_range(15)), gen_cnt});
				// Every fourth phase keeps the old list under the new registers.
				if (phase % 4 != 3)
					queue_request(fbpa_pkg::OP_INIT, $urandom());
				if (phase == 1) begin
					// Single-block pool: take it, find the pool empty, give it back.
					queue_request(fbpa_pkg::OP_ALLOC, 32'h0);
					queue_request(fbpa_pkg::OP_ALLOC, 32'h0);
					queue_request(fbpa_pkg::OP_FREE, 32'd8);
					queue_request(fbpa_pkg::OP_FREE, 32'd0);
					queue_request(fbpa_pkg::OP_ALLOC, 32'h0);
				end
			end

			repeat (ITEMS_PER_PHASE)
				queue_random_request(size_clamp(gen_bs), count_clamp(gen_cnt));
		end

		wait_for_drain();
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
